@@ src/twist_equalizer_fir_assert.svh @@
// Assertion macros for the twist equalizer block.
// Used by the top level only; needs signals named clock and reset in scope.
`ifndef TWIST_EQUALIZER_FIR_ASSERT_SVH
`define TWIST_EQUALIZER_FIR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TEQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("twist_equalizer_fir: assertion failed");
// next-cycle implication
`define TEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("twist_equalizer_fir: assertion failed");
`else
`define TEQ_ASSERT_NOW(label, ante, cons)
`define TEQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/teq_pkg.sv @@
// Package for the twist equalizer: widths, types and the coefficient table.
// No dependencies.
package teq_pkg;

   localparam int TAP_COUNT  = 9;
   localparam int HALF_COUNT = (TAP_COUNT + 1) / 2;
   localparam int SET_COUNT  = 19;
   localparam int SAMPLE_W   = 16;
   localparam int ACC_W      = 32;
   localparam int TWIST_W    = 5;
   localparam int TAP_IDX_W  = $clog2(TAP_COUNT);
   localparam int HALF_IDX_W = $clog2(HALF_COUNT);
   localparam int SET_IDX_W  = $clog2(SET_COUNT);
   localparam int FRAC_BITS  = 15;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SAMPLE_W-1:0] coef_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic signed [TWIST_W-1:0]  twist_type;
   typedef logic [TAP_IDX_W-1:0]       tap_idx_type;
   typedef logic [HALF_IDX_W-1:0]      half_idx_type;
   typedef logic [SET_IDX_W-1:0]       set_idx_type;

   typedef struct packed {
      logic clear;
      logic issue;
   } mac_ctrl_type;

   localparam twist_type   TWIST_RESET  = 5'sd6;
   localparam twist_type   TWIST_MIN    = -5'sd6;
   localparam twist_type   TWIST_MAX    = 5'sd12;
   localparam twist_type   TWIST_OFFSET = 5'sd6;
   localparam tap_idx_type TAP_LAST     = tap_idx_type'(TAP_COUNT - 1);
   localparam tap_idx_type TAP_CENTER   = tap_idx_type'(HALF_COUNT - 1);
   localparam sample_type  SAMPLE_MAX   = 16'sh7FFF;
   localparam sample_type  SAMPLE_MIN   = 16'sh8000;

   // outer taps up to the center; the other half mirrors
   localparam coef_type COEF_HALF [SET_COUNT][HALF_COUNT] = '{
      '{  16'sd89,   -16'sd1473, -16'sd5396, -16'sd9722,  16'sd32767 },
      '{  16'sd67,   -16'sd1516, -16'sd5381, -16'sd9603,  16'sd32767 },
      '{  16'sd40,   -16'sd1566, -16'sd5361, -16'sd9460,  16'sd32767 },
      '{  16'sd9,    -16'sd1624, -16'sd5334, -16'sd9287,  16'sd32767 },
      '{ -16'sd30,   -16'sd1691, -16'sd5296, -16'sd9074,  16'sd32767 },
      '{ -16'sd79,   -16'sd1769, -16'sd5241, -16'sd8806,  16'sd32767 },
      '{ -16'sd137,  -16'sd1855, -16'sd5161, -16'sd8469,  16'sd32767 },
      '{ -16'sd211,  -16'sd1950, -16'sd5036, -16'sd8026,  16'sd32767 },
      '{ -16'sd299,  -16'sd2040, -16'sd4841, -16'sd7444,  16'sd32767 },
      '{ -16'sd402,  -16'sd2101, -16'sd4510, -16'sd6627,  16'sd32767 },
      '{ -16'sd497,  -16'sd2047, -16'sd3919, -16'sd5444,  16'sd32767 },
      '{ -16'sd493,  -16'sd1638, -16'sd2767, -16'sd3593,  16'sd32767 },
      '{  16'sd0,     16'sd0,     16'sd0,     16'sd0,     16'sd32767 },
      '{ -16'sd3320,  16'sd6906,  16'sd3482, -16'sd22842, 16'sd32767 },
      '{ -16'sd3082,  16'sd6962,  16'sd3210, -16'sd22701, 16'sd32767 },
      '{ -16'sd2765,  16'sd7022,  16'sd2857, -16'sd22515, 16'sd32767 },
      '{ -16'sd2336,  16'sd7079,  16'sd2391, -16'sd22265, 16'sd32767 },
      '{ -16'sd1745,  16'sd7116,  16'sd1768, -16'sd21919, 16'sd32767 },
      '{ -16'sd950,   16'sd7092,  16'sd954,  -16'sd21447, 16'sd32767 }
   };

   function automatic coef_type coef_lookup(input set_idx_type set_idx,
                                            input tap_idx_type tap_idx);
      tap_idx_type folded;
      folded = (tap_idx > TAP_CENTER) ? tap_idx_type'(TAP_LAST - tap_idx) : tap_idx;
      return COEF_HALF[set_idx][folded[HALF_IDX_W-1:0]];
   endfunction

endpackage

@@ src/teq_stream_if.sv @@
// Valid/ready channel interfaces for the twist equalizer sample streams.
// Depends on teq_pkg for the sample type.
interface teq_req_if
   import teq_pkg::*;
   ();
   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface teq_rsp_if
   import teq_pkg::*;
   ();
   logic       valid;
   logic       ready;
   sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

@@ src/twist_equalizer_fir.sv @@
// Nine-tap symmetric FIR equalizer for Q15 samples. One request beat gives one
// response beat. From acceptance to the earliest next acceptance each sample passes
// through these steps: one multiplier is shared across the nine taps, then the product
// register drains, the result is truncated and saturated, and the idle state takes
// the next beat. A new sample is taken while a finished result still
// waits on the response side; the next result then holds the block until that beat
// leaves. The twist setting (-6..12, clamped) picks one of
// nine-teen coefficient sets; write it only while the block is idle. The
// eight-sample history is cleared by reset and kept across setting changes.
`include "twist_equalizer_fir_assert.svh"

module twist_equalizer_fir
   import teq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   teq_req_if.sink          req_bus,
   teq_rsp_if.source        rsp_bus,
   input  logic             csr_wr_en,
   input  logic [TWIST_W-1:0] csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type    state_ff, state_in;
   tap_idx_type  cnt_ff, cnt_in;
   sample_type   taps_ff [TAP_COUNT];
   sample_type   taps_in [TAP_COUNT];
   logic         rsp_valid_ff, rsp_valid_in;
   sample_type   rsp_data_ff, rsp_data_in;
   twist_type    twist_ff, twist_in;

   twist_type    twist_clamped;
   set_idx_type  set_idx;
   mac_ctrl_type mac_ctrl;
   acc_type      acc;
   sample_type   sat_value;
   logic         req_accept;
   logic         out_free;

   always_comb begin
      priority if (twist_ff < TWIST_MIN) begin
         twist_clamped = TWIST_MIN;
      end else if (twist_ff > TWIST_MAX) begin
         twist_clamped = TWIST_MAX;
      end else begin
         twist_clamped = twist_ff;
      end
   end
   assign set_idx = set_idx_type'($unsigned(twist_type'(twist_clamped + TWIST_OFFSET)));

   // acc >> 15 is a 17-bit value; it fits in 16 bits when its top two bits agree
   always_comb begin
      if (acc[ACC_W-1] != acc[ACC_W-2]) begin
         sat_value = acc[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         sat_value = sample_type'(acc[ACC_W-2:FRAC_BITS]);
      end
   end

   assign req_accept = req_bus.valid && req_bus.ready;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      taps_in      = taps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      twist_in     = csr_wr_en ? twist_type'(csr_wr_data) : twist_ff;
      mac_ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // shift in the new sample; the oldest history entry drops out
               taps_in[0] = req_bus.sample_in;
               for (int i = 1; i < TAP_COUNT; i++) begin
                  taps_in[i] = taps_ff[i-1];
               end
               cnt_in         = '0;
               mac_ctrl.clear = 1'b1;
               state_in       = ST_MAC;
            end
         end
         ST_MAC: begin
            // rotate so tap cnt sits at slot 0; nine steps restore the order
            mac_ctrl.issue = 1'b1;
            for (int i = 0; i < TAP_COUNT - 1; i++) begin
               taps_in[i] = taps_ff[i+1];
            end
            taps_in[TAP_COUNT-1] = taps_ff[0];
            if (cnt_ff == TAP_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + tap_idx_type'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_value;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         twist_ff     <= TWIST_RESET;
         for (int i = 0; i < TAP_COUNT; i++) begin
            taps_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         twist_ff     <= twist_in;
         taps_ff      <= taps_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   teq_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .coef  (coef_lookup(set_idx, cnt_ff)),
      .tap   (taps_ff[0]),
      .acc   (acc)
   );

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_data_ff;

   `TEQ_ASSERT_NEXT(a_busy_after_accept, req_accept, !req_bus.ready && acc == '0)
   `TEQ_ASSERT_NEXT(a_result_loaded, state_ff == ST_DONE && out_free, rsp_bus.valid)
   `TEQ_ASSERT_NOW(a_cnt_in_range, state_ff == ST_MAC, cnt_ff <= TAP_LAST)

endmodule

@@ src/teq_mac.sv @@
// Shared multiply-accumulate unit: registered 16x16 product, 32-bit wrapping sum.
// Depends on teq_pkg.
module teq_mac
   import teq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mac_ctrl_type ctrl,
   input  coef_type     coef,
   input  sample_type   tap,
   output acc_type      acc
);

   acc_type prod_ff, prod_in;
   logic    prod_vld_ff, prod_vld_in;
   acc_type acc_ff, acc_in;

   always_comb begin
      prod_in     = acc_type'(coef) * acc_type'(tap);
      prod_vld_in = ctrl.issue;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;   // wraps mod 2^32
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule
